### design/stt_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the software timer table
// no dependencies
package stt_pkg;

  // operation codes of an input word
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // timer modes of an add
  localparam logic MODE_ONESHOT  = 1'b0;
  localparam logic MODE_PERIODIC = 1'b1;

  // result kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  // at most this many fire results per tick
  localparam int RESULT_LIMIT = 16;
  localparam int FIRE_CNT_W   = $clog2(RESULT_LIMIT + 1);

  typedef struct packed {
    logic               operation;
    logic               timer_mode;
    logic [31:0]        period;
    logic signed [31:0] user_handle;
  } in_word_t;

  typedef struct packed {
    logic               reply_kind;
    logic [3:0]         slot_index;
    logic               add_ok;
    logic signed [31:0] fired_handle;
    logic [31:0]        tick_total;
    logic               last_of_run;
  } out_word_t;

  // one entry of the slot memory
  typedef struct packed {
    logic [31:0]        remaining;
    logic [31:0]        reload;
    logic signed [31:0] handle;
  } slot_entry_t;

endpackage

### design/software_timer_table_unit.sv
`timescale 1ns / 1ps
// software timer table: slot memory, add search and tick sweep
// depends on stt_pkg
//
// A word is taken when start is high and busy is low; results come out one per
// cycle on out_valid and cannot be held off. An add with a zero period is refused
// without raising busy, its reply on the result ports in the next cycle. Any other
// add searches the active bits for the lowest free slot, one slot per cycle, and
// stays busy until it claims a slot or finds the table full, with its single
// reply appearing in the cycle that busy drops. A tick sweeps the slot memory one
// entry per cycle (read, decrement, write back); its fire results, at most
// RESULT_LIMIT per tick, come out in slot order during the sweep, each held back
// until the next fire, so that the final one, sent in the cycle that busy drops,
// carries last_of_run.
// A tick with no expiry gives no result. No clearing pass is needed after reset.
module software_timer_table_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  stt_pkg::in_word_t in_word,
  output logic              out_valid,
  output stt_pkg::out_word_t out_word
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] SLOT_NUM_C = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] SLOT_MAX_C = IDX_W'(SLOT_COUNT - 1);
  localparam logic [stt_pkg::FIRE_CNT_W-1:0] FIRE_LIMIT_C =
    stt_pkg::FIRE_CNT_W'(stt_pkg::RESULT_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ADD   = 4'b0010,
    S_TICK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  // control state
  state_t                          state_r, state_nxt;
  logic [SLOT_COUNT-1:0]           active_r, active_nxt;
  logic [SLOT_COUNT-1:0]           periodic_r, periodic_nxt;
  logic [31:0]                     tick_cnt_r, tick_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            proc_valid_r, proc_valid_nxt;
  logic                            hold_valid_r, hold_valid_nxt;

  // datapath registers
  stt_pkg::in_word_t               req_r, req_nxt;
  stt_pkg::out_word_t              out_word_r, out_word_nxt;
  logic [IDX_W-1:0]                add_idx_r, add_idx_nxt;
  logic [CNT_W-1:0]                rd_cnt_r, rd_cnt_nxt;
  logic [IDX_W-1:0]                proc_idx_r, proc_idx_nxt;
  logic [stt_pkg::FIRE_CNT_W-1:0]  fire_cnt_r, fire_cnt_nxt;
  logic [3:0]                      hold_slot_r, hold_slot_nxt;
  logic signed [31:0]              hold_handle_r, hold_handle_nxt;

  // slot memory
  stt_pkg::slot_entry_t            slot_mem [SLOT_COUNT];
  stt_pkg::slot_entry_t            mem_rdata_r;
  stt_pkg::slot_entry_t            mem_wdata;
  logic                            mem_we;
  logic [IDX_W-1:0]                mem_waddr;
  logic [IDX_W-1:0]                rd_addr;

  // slot numbers as 4-bit result fields
  logic [IDX_W+3:0]                add_slot_ext;
  logic [IDX_W+3:0]                proc_slot_ext;
  logic [31:0]                     dec_ticks;

  assign add_slot_ext  = {4'b0000, add_idx_r};
  assign proc_slot_ext = {4'b0000, proc_idx_r};
  assign dec_ticks     = mem_rdata_r.remaining - 32'd1;
  assign rd_addr       = rd_cnt_r[IDX_W-1:0];

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // next state and datapath
  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    periodic_nxt    = periodic_r;
    tick_cnt_nxt    = tick_cnt_r;
    out_valid_nxt   = 1'b0;
    proc_valid_nxt  = 1'b0;
    hold_valid_nxt  = hold_valid_r;
    req_nxt         = req_r;
    out_word_nxt    = out_word_r;
    add_idx_nxt     = add_idx_r;
    rd_cnt_nxt      = rd_cnt_r;
    proc_idx_nxt    = proc_idx_r;
    fire_cnt_nxt    = fire_cnt_r;
    hold_slot_nxt   = hold_slot_r;
    hold_handle_nxt = hold_handle_r;
    mem_we          = 1'b0;
    mem_waddr       = proc_idx_r;
    mem_wdata       = mem_rdata_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_word;
          if (in_word.operation == stt_pkg::OP_ADD) begin
            if (in_word.period == 32'd0) begin
              // zero period is refused at once
              out_valid_nxt             = 1'b1;
              out_word_nxt.reply_kind   = stt_pkg::KIND_ADD;
              out_word_nxt.slot_index   = 4'd0;
              out_word_nxt.add_ok       = 1'b0;
              out_word_nxt.fired_handle = in_word.user_handle;
              out_word_nxt.tick_total   = tick_cnt_r;
              out_word_nxt.last_of_run  = 1'b1;
            end else begin
              add_idx_nxt = '0;
              state_nxt   = S_ADD;
            end
          end else begin
            tick_cnt_nxt   = tick_cnt_r + 32'd1;
            rd_cnt_nxt     = '0;
            fire_cnt_nxt   = '0;
            hold_valid_nxt = 1'b0;
            state_nxt      = S_TICK;
          end
        end
      end

      S_ADD: begin
        // look for the lowest free slot
        if (!active_r[add_idx_r]) begin
          mem_we                    = 1'b1;
          mem_waddr                 = add_idx_r;
          mem_wdata.remaining       = req_r.period;
          mem_wdata.reload          = req_r.period;
          mem_wdata.handle          = req_r.user_handle;
          active_nxt[add_idx_r]     = 1'b1;
          periodic_nxt[add_idx_r]   = (req_r.timer_mode == stt_pkg::MODE_PERIODIC);
          out_valid_nxt             = 1'b1;
          out_word_nxt.reply_kind   = stt_pkg::KIND_ADD;
          out_word_nxt.slot_index   = add_slot_ext[3:0];
          out_word_nxt.add_ok       = 1'b1;
          out_word_nxt.fired_handle = req_r.user_handle;
          out_word_nxt.tick_total   = tick_cnt_r;
          out_word_nxt.last_of_run  = 1'b1;
          state_nxt                 = S_IDLE;
        end else if (add_idx_r == SLOT_MAX_C) begin
          // table full
          out_valid_nxt             = 1'b1;
          out_word_nxt.reply_kind   = stt_pkg::KIND_ADD;
          out_word_nxt.slot_index   = 4'd0;
          out_word_nxt.add_ok       = 1'b0;
          out_word_nxt.fired_handle = req_r.user_handle;
          out_word_nxt.tick_total   = tick_cnt_r;
          out_word_nxt.last_of_run  = 1'b1;
          state_nxt                 = S_IDLE;
        end else begin
          add_idx_nxt = add_idx_r + 1'b1;
        end
      end

      S_TICK: begin
        // issue the read of the next slot
        if (rd_cnt_r < SLOT_NUM_C) begin
          proc_valid_nxt = 1'b1;
          proc_idx_nxt   = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt     = rd_cnt_r + 1'b1;
        end

        // decrement the slot read last cycle and write it back
        if (proc_valid_r && active_r[proc_idx_r]) begin
          mem_we = 1'b1;
          if (dec_ticks == 32'd0) begin
            if (periodic_r[proc_idx_r]) begin
              mem_wdata.remaining = mem_rdata_r.reload;
            end else begin
              mem_wdata.remaining    = dec_ticks;
              active_nxt[proc_idx_r] = 1'b0;
            end
            if (fire_cnt_r < FIRE_LIMIT_C) begin
              fire_cnt_nxt = fire_cnt_r + 1'b1;
              // a newer fire releases the held one as not last
              if (hold_valid_r) begin
                out_valid_nxt             = 1'b1;
                out_word_nxt.reply_kind   = stt_pkg::KIND_FIRE;
                out_word_nxt.slot_index   = hold_slot_r;
                out_word_nxt.add_ok       = 1'b0;
                out_word_nxt.fired_handle = hold_handle_r;
                out_word_nxt.tick_total   = tick_cnt_r;
                out_word_nxt.last_of_run  = 1'b0;
              end
              hold_valid_nxt  = 1'b1;
              hold_slot_nxt   = proc_slot_ext[3:0];
              hold_handle_nxt = mem_rdata_r.handle;
            end
          end else begin
            mem_wdata.remaining = dec_ticks;
          end
        end

        if (proc_valid_r && (proc_idx_r == SLOT_MAX_C)) begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        // the held fire is the last of the tick
        if (hold_valid_r) begin
          out_valid_nxt             = 1'b1;
          out_word_nxt.reply_kind   = stt_pkg::KIND_FIRE;
          out_word_nxt.slot_index   = hold_slot_r;
          out_word_nxt.add_ok       = 1'b0;
          out_word_nxt.fired_handle = hold_handle_r;
          out_word_nxt.tick_total   = tick_cnt_r;
          out_word_nxt.last_of_run  = 1'b1;
        end
        hold_valid_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      periodic_r   <= '0;
      tick_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      proc_valid_r <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      periodic_r   <= periodic_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      proc_valid_r <= proc_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    out_word_r    <= out_word_nxt;
    add_idx_r     <= add_idx_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    proc_idx_r    <= proc_idx_nxt;
    fire_cnt_r    <= fire_cnt_nxt;
    hold_slot_r   <= hold_slot_nxt;
    hold_handle_r <= hold_handle_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= slot_mem[rd_addr];
  end

endmodule
